### rtl/ptts_pkg.sv
// Shared types, constants and state codes for the periodic task tick scheduler.
package ptts_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int ID_W            = 32;
  localparam int IVL_W           = 16;
  localparam int TICK_W          = 32;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [1:0] KIND_FIRED  = 2'd0;
  localparam logic [1:0] KIND_ADDED  = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IVL_W-1:0] interval;
    logic             repeat_req;
    logic [ID_W-1:0]  task_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] task_id_res;
    logic            last;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [IVL_W-1:0] interval;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [TICK_W-1:0] dividend;
    logic [IVL_W-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [IVL_W-1:0] rem;
  } rem_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_RM,
    S_SKIP,
    S_DIV_RD,
    S_DIV_CHK,
    S_DIV_WAIT,
    S_SEL_INIT,
    S_SEL,
    S_FLUSH
  } state_t;

endpackage

### rtl/periodic_task_tick_scheduler.sv
// An add gives its result after the S_ADD state; a remove gives no result. A tick reads each
// slot in turn and runs the serial remainder unit for each valid slot with a nonzero interval,
// then a setup state, then one table scan per fired task (one RAM read port) until a scan finds
// none or the result budget is used up, then a flush state; the last result follows it.
// One item at a time: busy stays high until the item's work is done; results cannot stall.
// Synchronous reset clears all slots, the tick count and the id counter.
module periodic_task_tick_scheduler #(
  parameter int TABLE_DEPTH = ptts_pkg::DEF_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ptts_pkg::in_item_t item,
  output logic               result_valid,
  output ptts_pkg::result_t  result
);

  import ptts_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(TABLE_DEPTH - 1);
  localparam int RC_W = $clog2(MAX_RESULTS + 1);
  localparam logic [RC_W-1:0] RC_LAST = RC_W'(MAX_RESULTS - 1);
  localparam int ENT_W = $bits(entry_t);

  state_t state, state_next;

  in_item_t          item_q;
  logic [TICK_W-1:0] tick_count;
  logic [ID_W-1:0]   next_id;
  logic [ID_W-1:0]   id_new;

  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] rpt;
  logic [TABLE_DEPTH-1:0] fired;
  logic [TABLE_DEPTH-1:0] done;

  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] slot;
  logic             pv;
  logic [IDX_W-1:0] ps;

  logic             found;
  logic [ID_W-1:0]  best_id;
  logic [IDX_W-1:0] best_slot;
  logic             pending;
  logic [ID_W-1:0]  pending_id;
  logic [RC_W-1:0]  count;

  logic             free_found;
  logic [IDX_W-1:0] free_slot;

  logic             ram_we;
  entry_t           wr_entry;
  logic [ENT_W-1:0] rd_data;
  entry_t           rd_entry;

  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  logic    scan_end;
  logic    cand;
  logic    div_adv;
  logic    div_fire;
  logic    res_valid;
  result_t res_q;

  assign slot     = cnt[IDX_W-1:0];
  assign rd_entry = entry_t'(rd_data);
  assign id_new   = (next_id == '1) ? ID_W'(1) : next_id + 1'b1;
  assign busy     = (state != S_IDLE);

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_slot  = IDX_W'(i);
      end
    end
  end

  assign ram_we            = (state == S_ADD) && free_found;
  assign wr_entry.id       = id_new;
  assign wr_entry.interval = item_q.interval;

  ptts_ram #(
    .WIDTH  (ENT_W),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_slot),
    .wdata (wr_entry),
    .raddr (slot),
    .rdata (rd_data)
  );

  ptts_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    scan_end         = (cnt == DEPTH_C) && !pv;
    cand             = pv && fired[ps] && !done[ps] && (!found || rd_entry.id < best_id);
    div_adv          = 1'b0;
    div_fire         = 1'b0;
    rem_req.start    = 1'b0;
    rem_req.dividend = tick_count;
    rem_req.divisor  = rd_entry.interval;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (item.mode)
            MODE_TICK:   state_next = S_DIV_RD;
            MODE_ADD:    state_next = S_ADD;
            MODE_REMOVE: state_next = S_RM;
            default:     state_next = S_SKIP;
          endcase
        end
      end
      S_ADD: state_next = S_IDLE;
      S_SKIP: state_next = S_IDLE;
      S_RM: begin
        if (scan_end) begin
          state_next = S_IDLE;
        end
      end
      S_DIV_RD: state_next = S_DIV_CHK;
      S_DIV_CHK: begin
        if (!valid[slot] || rd_entry.interval == '0) begin
          div_adv  = 1'b1;
          div_fire = valid[slot];
        end else begin
          rem_req.start = 1'b1;
          state_next    = S_DIV_WAIT;
        end
        if (div_adv) begin
          state_next = (cnt == LAST_C) ? S_SEL_INIT : S_DIV_RD;
        end
      end
      S_DIV_WAIT: begin
        if (rem_rsp.done) begin
          div_adv    = 1'b1;
          div_fire   = (rem_rsp.rem == '0);
          state_next = (cnt == LAST_C) ? S_SEL_INIT : S_DIV_RD;
        end
      end
      S_SEL_INIT: state_next = S_SEL;
      S_SEL: begin
        // Stop once no fired task is left or the result budget is used up.
        if (scan_end && (!found || count == RC_LAST)) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      tick_count <= '0;
      next_id    <= '0;
      res_valid  <= 1'b0;
      pv         <= 1'b0;
      pending    <= 1'b0;
      found      <= 1'b0;
      cnt        <= '0;
      count      <= '0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            item_q <= item;
            cnt    <= '0;
            pv     <= 1'b0;
          end
        end
        S_ADD: begin
          res_valid  <= 1'b1;
          res_q.last <= 1'b1;
          if (free_found) begin
            valid[free_slot] <= 1'b1;
            rpt[free_slot]   <= item_q.repeat_req;
            next_id          <= id_new;
            res_q.kind        <= KIND_ADDED;
            res_q.task_id_res <= id_new;
          end else begin
            res_q.kind        <= KIND_FULL;
            res_q.task_id_res <= '0;
          end
        end
        S_RM: begin
          if (cnt != DEPTH_C) begin
            cnt <= cnt + 1'b1;
            pv  <= 1'b1;
            ps  <= slot;
          end else begin
            pv <= 1'b0;
          end
          if (pv && valid[ps] && rd_entry.id == item_q.task_id) begin
            valid[ps] <= 1'b0;
          end
        end
        S_DIV_CHK, S_DIV_WAIT: begin
          if (div_adv) begin
            fired[slot] <= div_fire;
            cnt         <= cnt + 1'b1;
          end
        end
        S_SEL_INIT: begin
          cnt     <= '0;
          pv      <= 1'b0;
          found   <= 1'b0;
          done    <= '0;
          count   <= '0;
          pending <= 1'b0;
        end
        S_SEL: begin
          if (cnt != DEPTH_C) begin
            cnt <= cnt + 1'b1;
            pv  <= 1'b1;
            ps  <= slot;
          end else begin
            pv <= 1'b0;
          end
          if (cand) begin
            found     <= 1'b1;
            best_id   <= rd_entry.id;
            best_slot <= ps;
          end
          if (scan_end && found) begin
            // The held firing is known not to be the last one once another is found.
            if (pending) begin
              res_valid         <= 1'b1;
              res_q.kind        <= KIND_FIRED;
              res_q.task_id_res <= pending_id;
              res_q.last        <= 1'b0;
            end
            done[best_slot] <= 1'b1;
            pending         <= 1'b1;
            pending_id      <= best_id;
            count           <= count + 1'b1;
            cnt             <= '0;
            found           <= 1'b0;
          end
        end
        S_FLUSH: begin
          if (pending) begin
            res_valid         <= 1'b1;
            res_q.kind        <= KIND_FIRED;
            res_q.task_id_res <= pending_id;
            res_q.last        <= 1'b1;
          end
          // One-shot tasks that fired leave the table, reported or not.
          valid      <= valid & ~(fired & ~rpt);
          tick_count <= tick_count + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign result_valid = res_valid;
  assign result       = res_q;

endmodule

### rtl/ptts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ptts_ram #(
  parameter int WIDTH  = 48,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ptts_rem.sv
// Restoring remainder unit: one dividend bit per cycle.
module ptts_rem (
  input  logic                clk,
  input  logic                rst,
  input  ptts_pkg::rem_req_t  req,
  output ptts_pkg::rem_rsp_t  rsp
);

  import ptts_pkg::*;

  localparam int STEP_W = $clog2(TICK_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TICK_W - 1);

  logic              run;
  logic [STEP_W-1:0] step;
  logic [TICK_W-1:0] quo;
  logic [IVL_W-1:0]  div;
  logic [IVL_W-1:0]  rem;
  logic              done;
  logic [IVL_W:0]    trial;
  logic [IVL_W:0]    diff;

  always_comb begin
    trial = {rem, quo[TICK_W-1]};
    diff  = trial - {1'b0, div};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run  <= 1'b1;
        step <= '0;
        quo  <= req.dividend;
        div  <= req.divisor;
        rem  <= '0;
      end else if (run) begin
        quo <= {quo[TICK_W-2:0], 1'b0};
        // The partial remainder stays below the divisor, so it fits in IVL_W bits.
        if (trial >= {1'b0, div}) begin
          rem <= diff[IVL_W-1:0];
        end else begin
          rem <= trial[IVL_W-1:0];
        end
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

### rtl/ptts_checker.sv
// Port-level checks on the scheduler's accept handshake and result sequencing, bound to the top level.
module ptts_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input ptts_pkg::result_t result
);

  import ptts_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("non-final result while the block is idle");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("result follows directly after a final result");

  a_full_id_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_FULL |-> result.task_id_res == '0 && result.last)
    else $error("refused add carries an id or is not final");

  a_added_id: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_ADDED |-> result.task_id_res != '0 && result.last)
    else $error("added task has id zero or is not final");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);

### verif/tb_periodic_task_tick_scheduler.sv
// Self-checking testbench for the periodic task tick scheduler with a cycle-free task table model.
`timescale 1ns / 100ps

module tb_periodic_task_tick_scheduler;
  import ptts_pkg::*;

  localparam int SLOTS          = DEF_TABLE_DEPTH;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 600;
  localparam int RANDOM_ITEMS   = 200;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  in_item_t item = '0;
  logic     result_valid;
  result_t  result;

  // Shadow copy of the task table and counters.
  logic              slot_valid [SLOTS];
  logic [ID_W-1:0]   slot_id    [SLOTS];
  logic [IVL_W-1:0]  slot_ivl   [SLOTS];
  logic              slot_rpt   [SLOTS];
  logic [TICK_W-1:0] tick_ctr;
  logic [ID_W-1:0]   last_id;

  result_t expected_results [$];
  int      errors = 0;
  int      quiet_cycles = 0;
  int      burst_left = 0;

  periodic_task_tick_scheduler #(.TABLE_DEPTH(SLOTS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void expect_result(result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_id[i]    = '0;
      slot_ivl[i]   = '0;
      slot_rpt[i]   = 1'b0;
    end
    tick_ctr = '0;
    last_id  = '0;
  endfunction

  function automatic int live_tasks();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (slot_valid[i]) n++;
    return n;
  endfunction

  // Fired tasks come out in ascending id order; equal ids keep slot order.
  function automatic void predict_tick_firings();
    logic    fired [SLOTS];
    logic    done  [SLOTS];
    int      best;
    result_t r;
    result_t firings [$];
    for (int i = 0; i < SLOTS; i++) begin
      fired[i] = slot_valid[i] && (slot_ivl[i] == '0 || (tick_ctr % slot_ivl[i]) == 0);
      done[i]  = 1'b0;
    end
    forever begin
      best = -1;
      for (int i = 0; i < SLOTS; i++)
        if (fired[i] && !done[i] && (best < 0 || slot_id[i] < slot_id[best])) best = i;
      if (best < 0) break;
      done[best] = 1'b1;
      if (firings.size() < MAX_RESULTS) begin
        r.kind        = KIND_FIRED;
        r.task_id_res = slot_id[best];
        r.last        = 1'b0;
        firings.insert(firings.size(), r);
      end
    end
    if (firings.size() > 0) firings[firings.size()-1].last = 1'b1;
    foreach (firings[k]) expect_result(firings[k]);
    for (int i = 0; i < SLOTS; i++) if (fired[i] && !slot_rpt[i]) slot_valid[i] = 1'b0;
    tick_ctr = tick_ctr + 1;
  endfunction

  function automatic void predict_add(logic [IVL_W-1:0] ivl, logic rpt);
    result_t r;
    r.kind        = KIND_FULL;
    r.task_id_res = '0;
    r.last        = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_valid[i]) begin
        last_id = last_id + 1;
        if (last_id == '0) last_id = 1;
        slot_valid[i] = 1'b1;
        slot_id[i]    = last_id;
        slot_ivl[i]   = ivl;
        slot_rpt[i]   = rpt;
        r.kind        = KIND_ADDED;
        r.task_id_res = last_id;
        break;
      end
    end
    expect_result(r);
  endfunction

  function automatic void apply_remove(logic [ID_W-1:0] tid);
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_id[i] == tid) slot_valid[i] = 1'b0;
  endfunction

  // Start stays high across a burst; it only drops when a gap follows.
  task automatic send_item(input logic [1:0] md, input logic [IVL_W-1:0] ivl,
                           input logic rpt, input logic [ID_W-1:0] tid);
    in_item_t it;
    it.mode       = md;
    it.interval   = ivl;
    it.repeat_req = rpt;
    it.task_id    = tid;
    item  <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    case (md)
      MODE_TICK:   predict_tick_firings();
      MODE_ADD:    predict_add(ivl, rpt);
      MODE_REMOVE: apply_remove(tid);
      default: ;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0 || busy);
  endtask

  task automatic test_empty_and_ignored();
    send_item(MODE_TICK, '0, 1'b0, '0);
    send_item(MODE_REMOVE, '0, 1'b0, 32'd1);
    send_item(2'd3, '1, 1'b1, '1);
  endtask

  task automatic test_add_tick_remove();
    send_item(MODE_ADD, 16'd0, 1'b1, '0);
    send_item(MODE_ADD, 16'hFFFF, 1'b0, '0);
    send_item(MODE_ADD, 16'd1, 1'b0, '0);
    send_item(MODE_ADD, 16'd2, 1'b1, '0);
    send_item(MODE_TICK, 16'hFFFF, 1'b1, '1);
    send_item(MODE_TICK, '0, 1'b0, '0);
    send_item(MODE_REMOVE, '1, 1'b1, 32'd1);
    send_item(MODE_ADD, 16'd3, 1'b1, '1);
  endtask

  // Fill every slot, get one refusal, then fire nearly the whole table in one tick.
  task automatic test_full_table();
    int n;
    n = 0;
    while (live_tasks() < SLOTS) begin
      send_item(MODE_ADD, (n % 3 == 0) ? 16'd1 : 16'd0, n[0], '0);
      n++;
    end
    send_item(MODE_ADD, 16'd4, 1'b1, 32'hA5A5_5A5A);
    send_item(MODE_TICK, '0, 1'b0, '0);
    send_item(MODE_ADD, 16'd5, 1'b0, '0);
    wait_idle();
  endtask

  function automatic logic [ID_W-1:0] pick_remove_id();
    logic [ID_W-1:0] live [$];
    for (int i = 0; i < SLOTS; i++) if (slot_valid[i]) live.insert(live.size(), slot_id[i]);
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return last_id + $urandom_range(1, 3);
      2:       return last_id - $urandom_range(0, 20);
      default: return (live.size() > 0) ? live[$urandom_range(0, live.size()-1)] : last_id;
    endcase
  endfunction

  function automatic logic [IVL_W-1:0] pick_interval();
    case ($urandom_range(0, 19))
      0, 1, 2:    return $urandom_range(0, 16'hFFFF);
      3:          return 16'hFFFF;
      4, 5, 6, 7: return $urandom_range(5, 12);
      default:    return $urandom_range(0, 4);
    endcase
  endfunction

  task automatic test_random();
    int sel;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_idle();
      sel = $urandom_range(0, 99);
      if (sel < 36)
        send_item(MODE_TICK, $urandom_range(0, 16'hFFFF), $urandom_range(0, 1), $urandom());
      else if (sel < 70)
        send_item(MODE_ADD, pick_interval(), $urandom_range(0, 2) != 0, $urandom());
      else if (sel < 95)
        send_item(MODE_REMOVE, $urandom_range(0, 16'hFFFF), $urandom_range(0, 1),
                  pick_remove_id());
      else
        send_item(2'd3, $urandom_range(0, 16'hFFFF), $urandom_range(0, 1), $urandom());
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d, task_id_res %0d, last %0d",
               result.kind, result.task_id_res, result.last);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, result.kind);
          errors++;
        end
        if (result.task_id_res !== want.task_id_res) begin
          $error("task_id_res: expected %0d, actual %0d", want.task_id_res, result.task_id_res);
          errors++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, result.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    clear_table();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_ignored();
    test_add_tick_remove();
    test_full_table();
    test_random();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/ptts_pkg.sv
rtl/ptts_ram.sv
rtl/ptts_rem.sv
rtl/periodic_task_tick_scheduler.sv
rtl/ptts_checker.sv
verif/tb_periodic_task_tick_scheduler.sv
